>>> rtl/core/kwc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwc_pkg: keyword counter shared definitions
// Request types, scanner-to-cell event bundle, default sizes and the fixed
// keyword table used by the cells.
// ----------------------------------------------------------------------------
package kwc_pkg;

    // fixed table geometry
    localparam int KEY_SLOTS = 12;
    localparam int KEY_CHARS = 8;

    // defaults for top level parameters
    localparam int DEF_WORD_MAX   = 19;
    localparam int DEF_NUM_KEYS   = 12;
    localparam int DEF_COUNT_BITS = 32;

    // input request: one text byte
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_req;

    // output request: one count of the report
    typedef struct packed {
        logic [3:0]  keyword_index;
        logic [31:0] hit_count;
        logic        last_in_report;
    } t_out_req;

    // per-byte event from the scanner, broadcast to every cell
    typedef struct packed {
        logic       start;     // byte opens a new word at position zero
        logic       ext;       // byte extends the open word at pos
        logic       pos_ok;    // pos lies inside the keyword width
        logic [2:0] pos;       // character position for ext
        logic [7:0] chr;       // the byte itself
        logic       fin_old;   // word open before this byte ends here
        logic [3:0] old_len;   // its length, clipped at 15
        logic       fin_new;   // word open after this byte ends at end of text
        logic [3:0] new_len;   // its length, clipped at 15
    } t_scan_ev;

    // keyword text, first character in the top byte, zero padded
    function automatic logic [KEY_CHARS*8-1:0] key_word(input logic [3:0] k);
        logic [KEY_CHARS*8-1:0] w;
        case (k)
            4'd0:    w = {"auto", 32'h0};
            4'd1:    w = {"break", 24'h0};
            4'd2:    w = {"case", 32'h0};
            4'd3:    w = {"char", 32'h0};
            4'd4:    w = {"const", 24'h0};
            4'd5:    w = "continue";
            4'd6:    w = {"default", 8'h0};
            4'd7:    w = "unsigned";
            4'd8:    w = {"void", 32'h0};
            4'd9:    w = "volatile";
            4'd10:   w = {"while", 24'h0};
            4'd11:   w = {"for", 40'h0};
            default: w = '0;
        endcase
        return w;
    endfunction

    // keyword length in characters
    function automatic logic [3:0] key_len(input logic [3:0] k);
        logic [3:0] n;
        case (k)
            4'd0:    n = 4'd4;
            4'd1:    n = 4'd5;
            4'd2:    n = 4'd4;
            4'd3:    n = 4'd4;
            4'd4:    n = 4'd5;
            4'd5:    n = 4'd8;
            4'd6:    n = 4'd7;
            4'd7:    n = 4'd8;
            4'd8:    n = 4'd4;
            4'd9:    n = 4'd8;
            4'd10:   n = 4'd5;
            4'd11:   n = 4'd3;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/kwc_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwc_scan: word scanner
// Classifies each accepted byte, tracks the open word and its length, and
// emits one event per byte telling the cells how the word moved.
// ----------------------------------------------------------------------------
module kwc_scan #(
    parameter int WORD_MAX = kwc_pkg::DEF_WORD_MAX
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_take,
    input  kwc_pkg::t_in_req   i_req,
    output kwc_pkg::t_scan_ev  o_ev
);
    import kwc_pkg::*;

    localparam int LEN_W = $clog2(WORD_MAX + 1);

    logic             r_inside;
    logic             n_inside;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] w_len_after;
    logic             w_letter;
    logic             w_alnum;
    t_scan_ev         w_ev;

    // character classes, ascii only
    always_comb begin
        w_letter = ((i_req.text_byte >= 8'h41) && (i_req.text_byte <= 8'h5a)) ||
                   ((i_req.text_byte >= 8'h61) && (i_req.text_byte <= 8'h7a));
        w_alnum  = w_letter ||
                   ((i_req.text_byte >= 8'h30) && (i_req.text_byte <= 8'h39));
    end

    // word tracking and event build
    always_comb begin
        n_inside    = r_inside;
        n_len       = r_len;
        w_ev        = '0;
        w_ev.chr    = i_req.text_byte;
        w_ev.pos    = r_len[2:0];
        w_ev.pos_ok = (r_len < LEN_W'(KEY_CHARS));
        w_ev.old_len = (r_len > LEN_W'(15)) ? 4'd15 : r_len[3:0];
        if (i_take) begin
            if (r_inside) begin
                if (w_alnum) begin
                    if (r_len < LEN_W'(WORD_MAX)) begin
                        w_ev.ext = 1'b1;
                        n_len    = r_len + LEN_W'(1);
                    end else begin
                        // overlong word splits here
                        w_ev.fin_old = 1'b1;
                        w_ev.start   = w_letter;
                        n_inside     = w_letter;
                        n_len        = w_letter ? LEN_W'(1) : '0;
                    end
                end else begin
                    w_ev.fin_old = 1'b1;
                    n_inside     = 1'b0;
                    n_len        = '0;
                end
            end else if (w_letter) begin
                w_ev.start = 1'b1;
                n_inside   = 1'b1;
                n_len      = LEN_W'(1);
            end
        end
        w_len_after  = n_len;
        w_ev.new_len = (w_len_after > LEN_W'(15)) ? 4'd15 : w_len_after[3:0];
        // end of text closes whatever is still open
        if (i_take && i_req.end_of_text) begin
            w_ev.fin_new = n_inside;
            n_inside     = 1'b0;
            n_len        = '0;
        end
    end

    assign o_ev = w_ev;

    // word state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_len    <= '0;
        end else begin
            r_inside <= n_inside;
            r_len    <= n_len;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/kwc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwc_cell: one keyword cell
// Follows the open word character by character against its own keyword,
// counts full matches with saturation, and shifts its count to the
// neighbor toward the output during the report.
// ----------------------------------------------------------------------------
module kwc_cell #(
    parameter int KEY_IDX    = 0,
    parameter int COUNT_BITS = kwc_pkg::DEF_COUNT_BITS
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  kwc_pkg::t_scan_ev     i_ev,
    input  wire                   i_shift,
    input  wire  [COUNT_BITS-1:0] i_next_count,
    output logic [COUNT_BITS-1:0] o_count
);
    import kwc_pkg::*;

    localparam logic [KEY_CHARS*8-1:0] KEY_WORD = key_word(4'(KEY_IDX));
    localparam logic [3:0]             KEY_LEN  = key_len(4'(KEY_IDX));

    logic                  r_match;
    logic                  n_match;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic [7:0]            w_key_chr;
    logic                  w_hit;

    // keyword character at the event position
    assign w_key_chr = KEY_WORD[{~i_ev.pos, 3'b000} +: 8];

    // running prefix match and word-end hit
    always_comb begin
        n_match = r_match;
        if (i_ev.start) begin
            n_match = (i_ev.chr == KEY_WORD[KEY_CHARS*8-1 -: 8]);
        end else if (i_ev.ext) begin
            n_match = r_match && i_ev.pos_ok && (i_ev.chr == w_key_chr);
        end
        // keywords are longer than one character, so at most one of these fires
        w_hit = (i_ev.fin_old && r_match && (i_ev.old_len == KEY_LEN)) ||
                (i_ev.fin_new && n_match && (i_ev.new_len == KEY_LEN));
    end

    // count: shift during report, saturating increment otherwise
    always_comb begin
        n_count = r_count;
        if (i_shift) begin
            n_count = i_next_count;
        end else if (w_hit && (r_count != '1)) begin
            n_count = r_count + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
            r_count <= '0;
        end else begin
            r_match <= n_match;
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule
`default_nettype wire

>>> rtl/core/keyword_occurrence_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_occurrence_counter: fixed keyword occurrence counter
// Splits a byte stream into words, counts exact keyword hits in a row of
// cells and reports all counts when the end of the text is flagged.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------
//  input   | in        | i_in_valid / o_in_ready    | i_in_req  (t_in_req)
//  output  | out       | o_out_valid / i_out_ready  | o_out_req (t_out_req)
//
//  one text byte is taken per cycle while no report is running
//  a byte flagged end_of_text starts a report of NUM_KEYS requests, taken
//  one per cycle from the head cell, while the receiver is ready, as the
//  counts shift down the chain; input is held off from that byte until the
//  last count is taken
//  reset clears the open word, all counts and the report; no clearing pass
// ----------------------------------------------------------------------------
module keyword_occurrence_counter #(
    parameter int WORD_MAX   = kwc_pkg::DEF_WORD_MAX,
    parameter int NUM_KEYS   = kwc_pkg::DEF_NUM_KEYS,
    parameter int COUNT_BITS = kwc_pkg::DEF_COUNT_BITS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  kwc_pkg::t_in_req   i_in_req,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output kwc_pkg::t_out_req  o_out_req
);
    import kwc_pkg::*;

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic                  r_busy;
    logic [IDX_W-1:0]      r_idx;
    logic                  w_take;
    logic                  w_shift;
    logic                  w_last;
    t_scan_ev              w_ev;
    logic [COUNT_BITS-1:0] w_count [NUM_KEYS];

    assign o_in_ready  = !r_busy;
    assign w_take      = i_in_valid && o_in_ready;
    assign o_out_valid = r_busy;
    assign w_shift     = o_out_valid && i_out_ready;
    assign w_last      = (r_idx == IDX_W'(NUM_KEYS - 1));

    // byte scanner
    kwc_scan #(
        .WORD_MAX (WORD_MAX)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_req   (i_in_req),
        .o_ev    (w_ev)
    );

    // chain of keyword cells, cell zero feeds the output
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_cell
        logic [COUNT_BITS-1:0] w_next;
        if (k == NUM_KEYS - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_count[k+1];
        end
        kwc_cell #(
            .KEY_IDX    (k),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ev         (w_ev),
            .i_shift      (w_shift),
            .i_next_count (w_next),
            .o_count      (w_count[k])
        );
    end

    // report sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_take && i_in_req.end_of_text) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_shift) begin
            if (w_last) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // output request from the head cell
    always_comb begin
        o_out_req                = '0;
        o_out_req.keyword_index  = 4'(r_idx);
        o_out_req.hit_count      = 32'(w_count[0]);
        o_out_req.last_in_report = w_last;
    end

`ifndef SYNTHESIS
    // end of text opens a report at the first keyword
    a_report_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_in_req.end_of_text) |=> (o_out_valid && (r_idx == '0)))
        else $error("report did not start at first keyword");

    // taken counts step through the table one by one
    a_report_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_shift && !w_last) |=> (o_out_valid && (r_idx == $past(r_idx) + IDX_W'(1))))
        else $error("report index did not advance by one");

    // the final count closes the report
    a_report_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_shift && w_last) |=> (!o_out_valid && o_in_ready))
        else $error("report did not close after last count");

    // counts are cleared once the report is done
    a_counts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_shift && w_last) |=> (w_count[0] == '0) && (w_count[NUM_KEYS-1] == '0))
        else $error("counts not cleared after report");
`endif

endmodule
`default_nettype wire

>>> tb/sv/keyword_occurrence_counter_chk.sv
// ----------------------------------------------------------------------------
// keyword_occurrence_counter_chk: keyword count predictor and report checker
// Watches both request channels of the keyword counter, splits the accepted
// text into words the way the block should, keeps its own keyword tallies
// and compares every report request with the predicted one in order.
// ----------------------------------------------------------------------------
module keyword_occurrence_counter_chk (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_ready,
    input  kwc_pkg::t_in_req   i_in_req,
    input  wire                i_out_valid,
    input  wire                i_out_ready,
    input  kwc_pkg::t_out_req  i_out_req,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import kwc_pkg::*;

    localparam int WORD_LIMIT = DEF_WORD_MAX;
    localparam int KEY_TOTAL  = DEF_NUM_KEYS;

    // keywords in report order
    string keyword_list [KEY_TOTAL] = '{
        "auto", "break", "case", "char", "const", "continue",
        "default", "unsigned", "void", "volatile", "while", "for"
    };

    // predicted scanner state and tallies
    logic [7:0]  word_buf [WORD_LIMIT];
    int unsigned word_len;
    bit          in_word;
    logic [31:0] key_hits [KEY_TOTAL];

    // report requests still owed by the block
    t_out_req    report_q [$];
    t_out_req    want;

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void open_word(input logic [7:0] c);
        word_buf[0] = c;
        word_len    = 1;
        in_word     = 1'b1;
    endfunction

    // close the open word and tally an exact keyword hit, saturating
    function automatic void close_word();
        bit same;
        if (in_word) begin
            for (int k = 0; k < KEY_TOTAL; k++) begin
                same = (word_len == keyword_list[k].len());
                for (int i = 0; same && i < word_len; i++)
                    if (word_buf[i] != keyword_list[k][i])
                        same = 1'b0;
                if (same && key_hits[k] != '1)
                    key_hits[k]++;
            end
        end
        in_word  = 1'b0;
        word_len = 0;
    endfunction

    // one accepted text byte; the flagged byte queues the whole report
    function automatic void absorb_byte(input t_in_req r);
        logic [7:0] c;
        t_out_req   entry;
        c = r.text_byte;
        if (in_word) begin
            if (is_letter(c) || is_digit(c)) begin
                if (word_len < WORD_LIMIT) begin
                    word_buf[word_len] = c;
                    word_len++;
                end else begin
                    close_word();
                    if (is_letter(c))
                        open_word(c);
                end
            end else begin
                close_word();
            end
        end else if (is_letter(c)) begin
            open_word(c);
        end

        if (r.end_of_text) begin
            close_word();
            for (int k = 0; k < KEY_TOTAL; k++) begin
                entry.keyword_index  = 4'(k);
                entry.hit_count      = key_hits[k];
                entry.last_in_report = (k == KEY_TOTAL - 1);
                report_q.push_back(entry);
                key_hits[k] = '0;
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
            o_fail_count++;
        end
    endfunction

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_len = 0;
            in_word  = 1'b0;
            foreach (key_hits[k])
                key_hits[k] = '0;
            report_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                absorb_byte(i_in_req);
            if (i_out_valid && i_out_ready) begin
                if (report_q.size() == 0) begin
                    $error("unexpected report request: index %0d, count %0d",
                           i_out_req.keyword_index, i_out_req.hit_count);
                    o_fail_count++;
                end else begin
                    want = report_q.pop_front();
                    check_field("keyword_index", 32'(want.keyword_index),
                                32'(i_out_req.keyword_index));
                    check_field("hit_count", want.hit_count, i_out_req.hit_count);
                    check_field("last_in_report", 32'(want.last_in_report),
                                32'(i_out_req.last_in_report));
                end
            end
        end
        o_pending = report_q.size();
    end

endmodule

>>> tb/sv/keyword_occurrence_counter_tb.sv
// ----------------------------------------------------------------------------
// keyword_occurrence_counter_tb: keyword counter testbench
// Feeds C-like text made of keywords, near misses, long words and stray
// bytes, each text closed by an end-of-text request, under random idling
// on both sides and a long output stall; the checker judges every report.
// ----------------------------------------------------------------------------
module keyword_occurrence_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kwc_pkg::*;

    localparam int RANDOM_ITEMS   = 470;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 30;

    typedef enum int {
        TOK_KEYWORD, TOK_VARIANT, TOK_IDENT, TOK_LONG, TOK_DIGIT_LEAD, TOK_NOISE
    } t_token_kind;

    typedef enum int {
        VAR_UPPER, VAR_TRAIL_DIGIT, VAR_TRAIL_LETTER, VAR_TRUNCATED, VAR_LEAD_LETTER
    } t_variant;

    typedef enum int {
        LONG_SPLIT_KEYWORD, LONG_DIGIT_KEYWORD, LONG_PLAIN
    } t_long_kind;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_req   in_req;
    logic      out_valid;
    logic      out_ready;
    t_out_req  out_req;
    int        fail_count;
    int        pending;

    bit         hold_req;
    bit         hold_done;
    bit         calm;
    int         items_sent;
    int         quiet_cycles;
    logic [7:0] text_q [$];

    string keyword_pool [12] = '{
        "auto", "break", "case", "char", "const", "continue",
        "default", "unsigned", "void", "volatile", "while", "for"
    };

    keyword_occurrence_counter i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_req   (out_req)
    );

    keyword_occurrence_counter_chk i_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_req    (out_req),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // text generation helpers
    function automatic bit is_alnum(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_word_char();
        return ($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter();
    endfunction

    // mostly spaces, otherwise any byte that cannot continue a word
    function automatic logic [7:0] rand_gap();
        logic [7:0] c;
        if ($urandom_range(0, 99) < 60)
            return 8'h20;
        do
            c = 8'($urandom_range(0, 255));
        while (is_alnum(c));
        return c;
    endfunction

    function automatic void push_string(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic void push_token(input t_token_kind kind);
        string kw;
        kw = keyword_pool[$urandom_range(0, 11)];
        case (kind)
            TOK_KEYWORD: begin
                push_string(kw);
            end
            // near misses that must not count
            TOK_VARIANT: begin
                case (t_variant'($urandom_range(0, 4)))
                    VAR_UPPER: begin
                        text_q.push_back(kw[0] - 8'd32);
                        push_string(kw.substr(1, kw.len() - 1));
                    end
                    VAR_TRAIL_DIGIT: begin
                        push_string(kw);
                        text_q.push_back(rand_digit());
                    end
                    VAR_TRAIL_LETTER: begin
                        push_string(kw);
                        text_q.push_back(rand_letter());
                    end
                    VAR_TRUNCATED: begin
                        push_string(kw.substr(0, kw.len() - 2));
                    end
                    default: begin
                        text_q.push_back(rand_letter());
                        push_string(kw);
                    end
                endcase
            end
            TOK_IDENT: begin
                text_q.push_back(rand_letter());
                repeat ($urandom_range(0, 7))
                    text_q.push_back(rand_word_char());
            end
            // words around the length limit, some split right before a keyword
            TOK_LONG: begin
                text_q.push_back(rand_letter());
                case (t_long_kind'($urandom_range(0, 2)))
                    LONG_SPLIT_KEYWORD: begin
                        repeat (18) text_q.push_back(rand_word_char());
                        push_string(kw);
                    end
                    LONG_DIGIT_KEYWORD: begin
                        repeat (18) text_q.push_back(rand_word_char());
                        text_q.push_back(rand_digit());
                        push_string(kw);
                    end
                    default: begin
                        repeat ($urandom_range(16, 44))
                            text_q.push_back(rand_word_char());
                    end
                endcase
            end
            TOK_DIGIT_LEAD: begin
                repeat ($urandom_range(1, 3))
                    text_q.push_back(rand_digit());
                push_string(kw);
            end
            default: begin
                repeat ($urandom_range(1, 4))
                    text_q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    function automatic t_token_kind pick_token();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return TOK_KEYWORD;
        if (roll < 55) return TOK_VARIANT;
        if (roll < 68) return TOK_IDENT;
        if (roll < 78) return TOK_LONG;
        if (roll < 86) return TOK_DIGIT_LEAD;
        return TOK_NOISE;
    endfunction

    // a short text of tokens, sometimes glued, sometimes ending mid-word
    function automatic void build_text();
        int ntok;
        ntok = $urandom_range(1, 9);
        for (int t = 0; t < ntok; t++) begin
            push_token(pick_token());
            if ($urandom_range(0, 99) < ((t < ntok - 1) ? 85 : 50))
                text_q.push_back(rand_gap());
        end
    endfunction

    // one byte request, held until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(0, 99) < 17) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{text_byte: b, end_of_text: last};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // send the queued text with the end flag on its final byte
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    // receiver: random ready, one long hold-off on request
    initial begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 17);
        end
    end

    // watchdog on cycles with no request moving on either channel
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int base;
        bit paused;
        in_valid   = 1'b0;
        in_req     = '0;
        rst_n      = 1'b0;
        hold_req   = 1'b0;
        calm       = 1'b0;
        paused     = 1'b0;
        items_sent = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // keyword closed by the end flag itself
        push_string("auto");
        send_text();
        // extreme bytes around a keyword, flag on a non-ASCII byte
        text_q.push_back(8'h00);
        push_string("char");
        text_q.push_back(8'hFF);
        send_text();
        // report with no word at all
        push_string(" ");
        send_text();
        // digit extends a keyword into a non-keyword
        push_string("while7 for");
        send_text();

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            if (!hold_req && items_sent - base >= 150)
                hold_req = 1'b1;
            if (!paused && items_sent - base >= 300) begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(negedge clk);
                while (pending != 0)
                    @(negedge clk);
            end
            calm = (items_sent - base >= 320) && (items_sent - base < 430);
            if ($urandom_range(0, 99) < 10) begin
                repeat ($urandom_range(1, 12))
                    text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                build_text();
            end
            send_text();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
